>>> design/utf8_utf16_unit_counter_core_assert.svh
// Assertion helpers shared by the counter core.
`ifndef UTF8_UTF16_UNIT_COUNTER_CORE_ASSERT_SVH
`define UTF8_UTF16_UNIT_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8C_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("counter core assertion failed");

// Next-cycle implication, checked outside reset.
`define U8C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("counter core assertion failed");

`endif

>>> design/u8u16c_pkg.sv
package u8u16c_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int SUM_W = COUNT_WIDTH + 1;
  localparam int OUT_W = 32;
  localparam int CODE_W = 21;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_W-1:0] out_count_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [2:0] len_t;
  typedef logic [7:0] byte_t;

  localparam byte_t LINE_FEED = 8'h0A;
  localparam byte_t CONT_MASK = 8'hC0;
  localparam byte_t CONT_TAG = 8'h80;
  localparam byte_t LEAD2_MIN = 8'hC0;
  localparam byte_t LEAD3_MIN = 8'hE0;
  localparam byte_t LEAD4_MIN = 8'hF0;
  localparam byte_t INVALID_MIN = 8'hF8;
  localparam code_t BMP_MAX = 21'h00FFFF;

  localparam len_t SEQ_NONE = 3'd0;
  localparam len_t SEQ_LEN_2 = 3'd2;
  localparam len_t SEQ_LEN_3 = 3'd3;
  localparam len_t SEQ_LEN_4 = 3'd4;

  // The counter never exceeds its maximum, so a carry out means saturation.
  function automatic count_t sat_add(count_t x, len_t n);
    logic [SUM_W-1:0] s;
    s = {1'b0, x} + SUM_W'(n);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

endpackage

>>> design/u8u16c_if.sv
interface u8u16c_in_if;
  import u8u16c_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;
  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface u8u16c_out_if;
  import u8u16c_pkg::*;
  logic       valid;
  logic       ready;
  out_count_t line_index;
  out_count_t column_units;
  out_count_t total_units;
  logic       sequence_pending;
  logic       text_done;
  modport source(output valid, line_index, column_units, total_units, sequence_pending,
                 text_done, input ready);
  modport sink(input valid, line_index, column_units, total_units, sequence_pending,
               text_done, output ready);
endinterface

>>> design/utf8_utf16_unit_counter_core.sv
// A result word is registered: it becomes valid in the cycle after its input byte is accepted.
// Throughput: one byte per cycle; the path is one saturating counter add per cycle.
// A result word that waits for ready holds off the next byte until it is taken.
// Reset (rst_n low, synchronous) clears the sequence state, the counters and
// the result valid; an accepted last byte also returns the sequence state and the counters to reset values.
module utf8_utf16_unit_counter_core (
  input logic clk,
  input logic rst_n,
  u8u16c_in_if.sink in_ch,
  u8u16c_out_if.source out_ch
);
  import u8u16c_pkg::*;

  `include "utf8_utf16_unit_counter_core_assert.svh"

  len_t   exp_r, exp_nxt;
  len_t   rcv_r, rcv_nxt;
  code_t  code_r, code_nxt;
  count_t line_r, line_nxt;
  count_t col_r, col_nxt;
  count_t unit_r, unit_nxt;

  logic       out_valid_r;
  out_count_t line_out_r, col_out_r, unit_out_r;
  logic       pend_out_r, done_out_r;

  logic   accept;
  logic   cont, pend, is_lf, line_inc, col_clear, pend_out;
  byte_t  b;
  code_t  shifted;
  len_t   rcv_inc, n_pre, n_body, n_post, n_add;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign b = in_ch.data_byte;

  always_comb begin
    cont = (b & CONT_MASK) == CONT_TAG;
    pend = exp_r != SEQ_NONE;
    is_lf = b == LINE_FEED;
    shifted = {code_r[CODE_W-7:0], b[5:0]};
    rcv_inc = rcv_r + 3'd1;
    exp_nxt = exp_r;
    rcv_nxt = rcv_r;
    code_nxt = code_r;
    n_pre = '0;
    n_body = '0;
    line_inc = 1'b0;
    col_clear = 1'b0;
    if (pend && cont) begin
      if (rcv_inc >= exp_r) begin
        n_body = (exp_r == SEQ_LEN_4 && shifted > BMP_MAX) ? 3'd2 : 3'd1;
        exp_nxt = SEQ_NONE;
        rcv_nxt = '0;
        code_nxt = '0;
      end else begin
        rcv_nxt = rcv_inc;
        code_nxt = shifted;
      end
    end else begin
      // A broken sequence counts one unit per byte, then this byte starts fresh.
      if (pend) n_pre = rcv_r;
      exp_nxt = SEQ_NONE;
      rcv_nxt = '0;
      code_nxt = '0;
      if (is_lf) begin
        n_body = 3'd1;
        line_inc = 1'b1;
        col_clear = 1'b1;
      end else if (b < LEAD2_MIN) begin
        n_body = 3'd1;
      end else if (b < LEAD3_MIN) begin
        exp_nxt = SEQ_LEN_2;
        rcv_nxt = 3'd1;
        code_nxt = {16'b0, b[4:0]};
      end else if (b < LEAD4_MIN) begin
        exp_nxt = SEQ_LEN_3;
        rcv_nxt = 3'd1;
        code_nxt = {17'b0, b[3:0]};
      end else if (b < INVALID_MIN) begin
        exp_nxt = SEQ_LEN_4;
        rcv_nxt = 3'd1;
        code_nxt = {18'b0, b[2:0]};
      end else begin
        n_body = 3'd1;
      end
    end
    n_post = (in_ch.last_byte && exp_nxt != SEQ_NONE) ? rcv_nxt : 3'd0;
    // Saturating adds in sequence equal one saturating add of the sum.
    n_add = n_pre + n_body + n_post;
    unit_nxt = sat_add(unit_r, n_add);
    col_nxt = col_clear ? '0 : sat_add(col_r, n_add);
    line_nxt = sat_add(line_r, {2'b0, line_inc});
    pend_out = (exp_nxt != SEQ_NONE) && !in_ch.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= SEQ_NONE;
      rcv_r <= '0;
      code_r <= '0;
      line_r <= '0;
      col_r <= '0;
      unit_r <= '0;
    end else if (accept) begin
      if (in_ch.last_byte) begin
        exp_r <= SEQ_NONE;
        rcv_r <= '0;
        code_r <= '0;
        line_r <= '0;
        col_r <= '0;
        unit_r <= '0;
      end else begin
        exp_r <= exp_nxt;
        rcv_r <= rcv_nxt;
        code_r <= code_nxt;
        line_r <= line_nxt;
        col_r <= col_nxt;
        unit_r <= unit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_out_r <= OUT_W'(line_nxt);
      col_out_r <= OUT_W'(col_nxt);
      unit_out_r <= OUT_W'(unit_nxt);
      pend_out_r <= pend_out;
      done_out_r <= in_ch.last_byte;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.line_index = line_out_r;
  assign out_ch.column_units = col_out_r;
  assign out_ch.total_units = unit_out_r;
  assign out_ch.sequence_pending = pend_out_r;
  assign out_ch.text_done = done_out_r;

  `U8C_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_ch.last_byte,
                   exp_r == SEQ_NONE && unit_r == '0 && line_r == '0 && col_r == '0)
  `U8C_ASSERT_NOW(a_done_not_pending, clk, rst_n, out_valid_r && done_out_r, !pend_out_r)
  `U8C_ASSERT_NOW(a_rcv_in_range, clk, rst_n, exp_r != SEQ_NONE,
                  rcv_r != 3'd0 && rcv_r < exp_r)
  `U8C_ASSERT_NEXT(a_lf_clears_col, clk, rst_n, accept && in_ch.data_byte == LINE_FEED,
                   col_r == '0)
  `U8C_ASSERT_NEXT(a_units_grow, clk, rst_n, accept && !in_ch.last_byte,
                   unit_r >= $past(unit_r) && line_r >= $past(line_r))

endmodule
